// ----- rtl/core/length_prefixed_deframer_assert.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LPD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lpd_pkg.sv -----
`timescale 1ns / 1ps
package lpd_pkg;

  typedef enum logic [1:0] {
    PH_LOW   = 2'd0,
    PH_HIGH  = 2'd1,
    PH_BODY  = 2'd2,
    PH_STUCK = 2'd3
  } phase_t;

  localparam logic [1:0] REG_MAX_LENGTH   = 2'd0;
  localparam logic [1:0] REG_ERROR_WEIGHT = 2'd1;
  localparam logic [1:0] REG_ERROR_LIMIT  = 2'd2;

  localparam logic RES_MSG = 1'b0;
  localparam logic RES_ERR = 1'b1;

  localparam int          LEN_W    = 15;
  localparam int          ERR_W    = 16;
  localparam logic [14:0] HDR_MIN  = 15'd2;
  localparam int          Q_DEPTH  = 4;
  localparam int          Q_CNT_W  = 3;

  typedef struct packed {
    logic [LEN_W-1:0] max_length;
    logic [ERR_W-1:0] error_weight;
    logic [ERR_W-1:0] error_limit;
  } cfg_t;

  typedef struct packed {
    logic             result_kind;
    logic [7:0]       out_byte;
    logic             frame_first;
    logic             frame_last;
    logic [LEN_W-1:0] frame_length;
    logic             connection_error;
  } result_t;

endpackage

// ----- rtl/core/lpd_if.sv -----
`timescale 1ns / 1ps
interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_last;

  modport source (output valid, output data_byte, output chunk_last, input ready);
  modport sink   (input valid, input data_byte, input chunk_last, output ready);
endinterface

interface lpd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  out_byte;
  logic        frame_first;
  logic        frame_last;
  logic [14:0] frame_length;
  logic        connection_error;

  modport source (output valid, output result_kind, output out_byte, output frame_first,
                  output frame_last, output frame_length, output connection_error,
                  input ready);
  modport sink   (input valid, input result_kind, input out_byte, input frame_first,
                  input frame_last, input frame_length, input connection_error,
                  output ready);
endinterface

// ----- rtl/core/lpd_cfg_regs.sv -----
`timescale 1ns / 1ps
module lpd_cfg_regs
  import lpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_MAX_LENGTH:   cfg_nxt.max_length   = cfg_pwdata[LEN_W-1:0];
        REG_ERROR_WEIGHT: cfg_nxt.error_weight = cfg_pwdata[ERR_W-1:0];
        REG_ERROR_LIMIT:  cfg_nxt.error_limit  = cfg_pwdata[ERR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_MAX_LENGTH:   cfg_prdata = {17'd0, cfg_r.max_length};
      REG_ERROR_WEIGHT: cfg_prdata = {16'd0, cfg_r.error_weight};
      REG_ERROR_LIMIT:  cfg_prdata = {16'd0, cfg_r.error_limit};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_length   <= 15'd8192;
      cfg_r.error_weight <= 16'd1;
      cfg_r.error_limit  <= 16'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/core/lpd_result_queue.sv -----
`timescale 1ns / 1ps
`include "length_prefixed_deframer_assert.svh"
module lpd_result_queue
  import lpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_cnt,
  input  result_t          item0,
  input  result_t          item1,
  output logic             has_room,
  lpd_out_if.source        out_ch
);

  result_t            slot_r   [Q_DEPTH];
  result_t            slot_nxt [Q_DEPTH];
  logic [Q_CNT_W-1:0] count_r;
  logic [Q_CNT_W-1:0] count_nxt;
  logic [Q_CNT_W-1:0] base;
  logic               pop;

  // Room for the two items a header can produce, whatever the sink does.
  assign has_room = count_r <= Q_CNT_W'(Q_DEPTH - 2);

  assign out_ch.valid            = count_r != '0;
  assign out_ch.result_kind      = slot_r[0].result_kind;
  assign out_ch.out_byte         = slot_r[0].out_byte;
  assign out_ch.frame_first      = slot_r[0].frame_first;
  assign out_ch.frame_last       = slot_r[0].frame_last;
  assign out_ch.frame_length     = slot_r[0].frame_length;
  assign out_ch.connection_error = slot_r[0].connection_error;

  assign pop       = out_ch.valid && out_ch.ready;
  assign base      = count_r - Q_CNT_W'(pop);
  assign count_nxt = base + Q_CNT_W'(push_cnt);

  always_comb begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      // Shift toward the head on a pop, then drop new items behind the survivors.
      if (pop && i < Q_DEPTH - 1) begin
        slot_nxt[i] = slot_r[i+1];
      end else begin
        slot_nxt[i] = slot_r[i];
      end
      if (push_cnt != 2'd0 && base == Q_CNT_W'(i)) begin
        slot_nxt[i] = item0;
      end
      if (push_cnt == 2'd2 && base + Q_CNT_W'(1) == Q_CNT_W'(i)) begin
        slot_nxt[i] = item1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  `LPD_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= Q_CNT_W'(Q_DEPTH), "queue overfull")
  `LPD_ASSERT_IMPL(a_push_room, clk, rst_n, push_cnt != 2'd0, has_room, "push without room")

endmodule

// ----- rtl/core/length_prefixed_deframer.sv -----
`timescale 1ns / 1ps
// Length-prefixed deframer: takes one stream byte per cycle and splits it into messages
// whose first two bytes are a little-endian length that counts the header itself. A byte
// is accepted in every cycle while the four-entry result queue has room for two more
// items; each accepted byte updates the framing state and its items are registered
// in the queue that drives the output. The high header byte of a good header gives two
// items (both header bytes), the low header byte gives none, body bytes give one each.
// A header above max_length (clamped to MAX_FRAME) or below two locks the block until
// reset: it then reports one framing error for that header and one per later chunk,
// adding error_weight to a saturating 16-bit total that drives connection_error.
`include "length_prefixed_deframer_assert.svh"
module length_prefixed_deframer
  import lpd_pkg::*;
#(
  parameter int MAX_FRAME = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  lpd_in_if.sink      in_ch,
  lpd_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [LEN_W-1:0] FRAME_CAP = LEN_W'(MAX_FRAME);

  cfg_t             cfg;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       header_low_r, header_low_nxt;
  logic [LEN_W-1:0] bytes_seen_r, bytes_seen_nxt;
  logic [LEN_W-1:0] msg_len_r, msg_len_nxt;
  logic [ERR_W-1:0] err_total_r, err_total_nxt;
  logic             chunk_start_r, chunk_start_nxt;

  logic             in_fire;
  logic             has_room;
  logic [1:0]       push_cnt;
  result_t          res0, res1;
  logic [LEN_W-1:0] len_limit;
  logic [15:0]      hdr;
  logic             hdr_bad;
  logic [ERR_W:0]   err_sum;
  logic [ERR_W-1:0] err_sat;
  logic [LEN_W-1:0] seen;
  logic             body_done;

  lpd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lpd_result_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .item0    (res0),
    .item1    (res1),
    .has_room (has_room),
    .out_ch   (out_ch)
  );

  assign in_ch.ready = has_room;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign len_limit = (cfg.max_length > FRAME_CAP) ? FRAME_CAP : cfg.max_length;
  assign hdr       = {in_ch.data_byte, header_low_r};
  assign hdr_bad   = hdr[15] || (hdr[LEN_W-1:0] < HDR_MIN) || (hdr[LEN_W-1:0] > len_limit);
  assign err_sum   = {1'b0, err_total_r} + {1'b0, cfg.error_weight};
  assign err_sat   = err_sum[ERR_W] ? '1 : err_sum[ERR_W-1:0];
  assign seen      = bytes_seen_r + LEN_W'(1);
  assign body_done = seen >= msg_len_r;

  always_comb begin
    phase_nxt       = phase_r;
    header_low_nxt  = header_low_r;
    bytes_seen_nxt  = bytes_seen_r;
    msg_len_nxt     = msg_len_r;
    err_total_nxt   = err_total_r;
    chunk_start_nxt = chunk_start_r;
    push_cnt        = 2'd0;
    res0            = '0;
    res1            = '0;
    res0.connection_error = err_total_r >= cfg.error_limit;
    res1.connection_error = err_total_r >= cfg.error_limit;
    if (in_fire) begin
      chunk_start_nxt = in_ch.chunk_last;
      unique case (phase_r)
        PH_LOW: begin
          header_low_nxt = in_ch.data_byte;
          bytes_seen_nxt = LEN_W'(1);
          phase_nxt      = PH_HIGH;
        end
        PH_HIGH: begin
          if (hdr_bad) begin
            phase_nxt      = PH_STUCK;
            msg_len_nxt    = '0;
            bytes_seen_nxt = '0;
            err_total_nxt  = err_sat;
            push_cnt       = 2'd1;
            res0.result_kind      = RES_ERR;
            res0.connection_error = err_sat >= cfg.error_limit;
          end else begin
            msg_len_nxt       = hdr[LEN_W-1:0];
            push_cnt          = 2'd2;
            res0.result_kind  = RES_MSG;
            res0.out_byte     = header_low_r;
            res0.frame_first  = 1'b1;
            res0.frame_length = hdr[LEN_W-1:0];
            res1.result_kind  = RES_MSG;
            res1.out_byte     = in_ch.data_byte;
            res1.frame_length = hdr[LEN_W-1:0];
            // A two-byte message is header only: it ends here.
            if (hdr[LEN_W-1:0] == HDR_MIN) begin
              res1.frame_last = 1'b1;
              phase_nxt       = PH_LOW;
              bytes_seen_nxt  = '0;
            end else begin
              phase_nxt      = PH_BODY;
              bytes_seen_nxt = HDR_MIN;
            end
          end
        end
        PH_BODY: begin
          push_cnt          = 2'd1;
          res0.result_kind  = RES_MSG;
          res0.out_byte     = in_ch.data_byte;
          res0.frame_last   = body_done;
          res0.frame_length = msg_len_r;
          if (body_done) begin
            phase_nxt      = PH_LOW;
            bytes_seen_nxt = '0;
          end else begin
            bytes_seen_nxt = seen;
          end
        end
        PH_STUCK: begin
          // Drop every byte; report once at the head of each chunk.
          if (chunk_start_r) begin
            err_total_nxt         = err_sat;
            push_cnt              = 2'd1;
            res0.result_kind      = RES_ERR;
            res0.connection_error = err_sat >= cfg.error_limit;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LOW;
      header_low_r  <= '0;
      bytes_seen_r  <= '0;
      msg_len_r     <= '0;
      err_total_r   <= '0;
      chunk_start_r <= 1'b1;
    end else begin
      phase_r       <= phase_nxt;
      header_low_r  <= header_low_nxt;
      bytes_seen_r  <= bytes_seen_nxt;
      msg_len_r     <= msg_len_nxt;
      err_total_r   <= err_total_nxt;
      chunk_start_r <= chunk_start_nxt;
    end
  end

  `LPD_ASSERT_NEXT(a_stuck_holds, clk, rst_n, phase_r == PH_STUCK, phase_r == PH_STUCK, "left stuck phase")
  `LPD_ASSERT_IMPL(a_err_monotonic, clk, rst_n, $past(rst_n), err_total_r >= $past(err_total_r), "error total fell")
  `LPD_ASSERT_IMPL(a_body_len, clk, rst_n, phase_r == PH_BODY, msg_len_r > bytes_seen_r, "body past length")

endmodule
